### rtl/mpm_pkg.sv
// Package for matrix_power_mod: sequencer states, fixed field widths and the
// largest matrix dimension. No dependencies.
package mpm_pkg;
  localparam int unsigned ElemW  = 31;
  localparam int unsigned DimW   = 4;
  localparam int unsigned MaxDim = 8;
  localparam logic [0:0] CfgModulus   = 1'b0;
  localparam logic [0:0] CfgDimension = 1'b1;

  typedef enum logic [3:0] {
    StLoad,
    StInit,
    StFindBit,
    StRdA,
    StMul,
    StRed,
    StAcc,
    StStore,
    StCopy,
    StCopyWr,
    StOutRd,
    StOut
  } state_e;
endpackage

### rtl/mpm_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module mpm_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/matrix_power_mod.sv
// Top level of matrix_power_mod: modular matrix power by square-and-multiply.
// Depends on mpm_pkg and mpm_ram.
//
// channel | dir | handshake            | payload
// s_axis  | in  | tvalid/tready        | tdata=element,exponent; tlast=last_element
// m_axis  | out | tvalid/tready        | tdata=result_element; tlast=last_result
// cfg     | in  | cfg_we_i             | index 0 modulus, 1 dimension
//
// Loading accepts words only in the load state. After the last word the identity is set up
// in the result store, one cell at a time. Each multiply-accumulate uses one shared 31x31
// multiplier and one restoring remainder unit; an exponent needs up to 62 products.
// Output reads each word from the result store before presenting it; output stalls
// hold the sequencer.
// Reset clears control and arithmetic registers; stores are undefined until loaded.
module matrix_power_mod
  import mpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [30:0] element, [61:31] exponent
  input  logic        s_axis_tlast_i,   // last_element
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [30:0] result_element
  output logic        m_axis_tlast_o    // last_result
);
  localparam int unsigned Cells = MaxDim * MaxDim;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned IW    = $clog2(MaxDim + 1);
  localparam int unsigned PW    = 2 * ElemW;
  localparam logic [5:0]  RedLast = 6'(PW - 1);

  state_e state_q, state_d;
  logic [ElemW-1:0] modulus_q;
  logic [DimW-1:0]  dimension_q;
  logic [NW-1:0]    load_idx_q;
  logic [ElemW-1:0] exp_q;
  logic [4:0]       bit_q;
  logic             mulb_q;      // 0 square, 1 multiply by base
  logic [IW-1:0]    i_q, j_q, l_q;
  logic [ElemW-1:0] acc_q, rem_q;
  logic [PW-1:0]    prod_q;
  logic [5:0]       cnt_q;
  logic [AW-1:0]    oidx_q;

  logic [IW-1:0]    d_eff;
  logic [NW-1:0]    n_cells;
  logic [ElemW-1:0] m_eff;
  always_comb begin
    if (dimension_q == '0) d_eff = IW'(1);
    else if (32'(dimension_q) > MaxDim) d_eff = IW'(MaxDim);
    else d_eff = IW'(dimension_q);
    n_cells = NW'(d_eff) * NW'(d_eff);
    m_eff = (modulus_q == '0) ? ElemW'(1) : modulus_q;
  end

  // RAM ports
  logic             bwe, rwe, swe;
  logic [AW-1:0]    bwa, rwa, swa, bra, rra, r2a, sra;
  logic [ElemW-1:0] bwd, rwd, swd, brd, rrd, r2d, srd;

  mpm_ram #(.Width(ElemW), .Depth(Cells)) u_base (
    .clk_i, .we_i(bwe), .waddr_i(bwa), .wdata_i(bwd), .raddr_i(bra), .rdata_o(brd));
  mpm_ram #(.Width(ElemW), .Depth(Cells)) u_res (
    .clk_i, .we_i(rwe), .waddr_i(rwa), .wdata_i(rwd), .raddr_i(rra), .rdata_o(rrd));
  // second copy of the result store for the column operand of a square
  mpm_ram #(.Width(ElemW), .Depth(Cells)) u_res2 (
    .clk_i, .we_i(rwe), .waddr_i(rwa), .wdata_i(rwd), .raddr_i(r2a), .rdata_o(r2d));
  mpm_ram #(.Width(ElemW), .Depth(Cells)) u_scr (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));

  logic s_acc;
  assign s_axis_tready_o = (state_q == StLoad);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  logic [AW-1:0] a_idx, b_idx, ij_idx;
  assign a_idx  = AW'(i_q) * AW'(d_eff) + AW'(l_q);
  assign b_idx  = AW'(l_q) * AW'(d_eff) + AW'(j_q);
  assign ij_idx = AW'(i_q) * AW'(d_eff) + AW'(j_q);

  logic last_j, last_l, last_cell, last_out;
  assign last_j    = (j_q == d_eff - IW'(1));
  assign last_l    = (l_q == d_eff - IW'(1));
  assign last_cell = ({1'b0, ij_idx} == n_cells - NW'(1));
  assign last_out  = ({1'b0, oidx_q} == n_cells - NW'(1));

  // restoring remainder, one product bit per cycle
  logic [ElemW:0] shifted, sub_res;
  logic           ge;
  assign shifted = {rem_q, prod_q[PW-1]};
  assign ge      = shifted >= {1'b0, m_eff};
  assign sub_res = shifted - {1'b0, m_eff};

  logic [ElemW:0]   acc_sum, acc_sub;
  logic [ElemW-1:0] acc_next;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, rem_q};
  assign acc_sub  = acc_sum - {1'b0, m_eff};
  assign acc_next = (acc_sum >= {1'b0, m_eff}) ? acc_sub[ElemW-1:0] : acc_sum[ElemW-1:0];

  logic [ElemW-1:0] bop;
  assign bop = mulb_q ? brd : r2d;

  logic [IW-1:0] i_next, j_next;
  always_comb begin
    if (last_cell) begin
      i_next = '0;
      j_next = '0;
    end else if (last_j) begin
      i_next = i_q + IW'(1);
      j_next = '0;
    end else begin
      i_next = i_q;
      j_next = j_q + IW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad:    if (s_acc && s_axis_tlast_i) state_d = StInit;
      StInit:    if (last_cell) state_d = (exp_q == '0) ? StOutRd : StFindBit;
      StFindBit: if (exp_q[bit_q]) state_d = StRdA;
      StRdA:     state_d = StMul;
      StMul:     state_d = StRed;
      StRed:     if (cnt_q == RedLast) state_d = StAcc;
      StAcc:     state_d = last_l ? StStore : StRdA;
      StStore:   state_d = last_cell ? StCopy : StRdA;
      StCopy:    state_d = StCopyWr;
      StCopyWr: begin
        if (last_cell) begin
          if (!mulb_q && exp_q[bit_q]) state_d = StRdA;
          else if (bit_q == '0) state_d = StOutRd;
          else state_d = StRdA;
        end else state_d = StCopy;
      end
      StOutRd:   state_d = StOut;
      StOut:     if (m_axis_tready_i) state_d = last_out ? StLoad : StOutRd;
      default:   state_d = StLoad;
    endcase
  end

  always_comb begin
    bwe = s_acc && (load_idx_q < n_cells);
    bwa = load_idx_q[AW-1:0];
    bwd = s_axis_tdata_i[ElemW-1:0];
    bra = b_idx;
    rra = (state_q == StOutRd || state_q == StOut) ? oidx_q : a_idx;
    r2a = b_idx;
    sra = ij_idx;
    rwe = (state_q == StInit) || (state_q == StCopyWr);
    rwa = ij_idx;
    rwd = (state_q == StInit) ? ((i_q == j_q) ? ElemW'(1) : '0) : srd;
    swe = (state_q == StStore);
    swa = ij_idx;
    swd = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; modulus_q <= ElemW'(32'h7FFFFFFF); dimension_q <= DimW'(8);
      load_idx_q <= '0; exp_q <= '0; bit_q <= '0; mulb_q <= 1'b0;
      i_q <= '0; j_q <= '0; l_q <= '0; cnt_q <= '0; oidx_q <= '0;
      acc_q <= '0; rem_q <= '0; prod_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgModulus:   modulus_q <= cfg_data_i;
          CfgDimension: dimension_q <= cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StLoad: if (s_acc) begin
          if (s_axis_tlast_i) begin
            load_idx_q <= '0; exp_q <= s_axis_tdata_i[PW-1:ElemW];
            i_q <= '0; j_q <= '0; l_q <= '0; bit_q <= 5'd30;
            acc_q <= '0; oidx_q <= '0;
          end else if (load_idx_q < n_cells) begin
            load_idx_q <= load_idx_q + 1'b1;
          end
        end
        StInit: begin
          i_q <= i_next;
          j_q <= j_next;
        end
        StFindBit: begin
          if (!exp_q[bit_q]) bit_q <= bit_q - 1'b1;
          else mulb_q <= 1'b0;
        end
        StRdA: ;
        StMul: begin
          prod_q <= PW'(rrd) * PW'(bop);
          rem_q  <= '0;
          cnt_q  <= '0;
        end
        StRed: begin
          prod_q <= {prod_q[PW-2:0], 1'b0};
          rem_q  <= ge ? sub_res[ElemW-1:0] : shifted[ElemW-1:0];
          cnt_q  <= cnt_q + 1'b1;
        end
        StAcc: begin
          acc_q <= acc_next;
          if (!last_l) l_q <= l_q + 1'b1;
        end
        StStore: begin
          acc_q <= '0; l_q <= '0;
          i_q <= i_next;
          j_q <= j_next;
        end
        StCopy: ;
        StCopyWr: begin
          i_q <= i_next;
          j_q <= j_next;
          if (last_cell) begin
            if (!mulb_q && exp_q[bit_q]) mulb_q <= 1'b1;
            else begin mulb_q <= 1'b0; bit_q <= bit_q - 1'b1; end
          end
        end
        StOutRd: ;
        StOut: if (m_axis_tready_i && !last_out) oidx_q <= oidx_q + 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {1'b0, rrd};
  assign m_axis_tlast_o  = last_out;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !s_axis_tready_o) else $error("ready while busy");
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_idx_q <= n_cells) else $error("load index overrun");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output word dropped while stalled");
  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("word after last");
`endif
endmodule
